// ----- rtl/assert_macros.svh -----
// assertion macros used by the controller of the path heading and curvature block
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge out of reset
`define ASSERT_AT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// condition must never be seen at a clock edge out of reset
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

// ----- rtl/phc_pkg.sv -----
// shared types, constants and the arctangent table of the heading and curvature block
`default_nettype none

package phc_pkg;

  localparam int CURV_WIDTH      = 32;
  localparam int QUOT_BITS       = 31;
  localparam int CURV_SHIFT      = 40;
  localparam int SQRT_SHIFT      = 32;
  localparam int CORDIC_PRESHIFT = 24;
  localparam int ANGLE_WIDTH     = 32;
  localparam int ANGLE_IDX_W     = 5;
  localparam int MUL_STEPS       = 4;

  localparam logic [ANGLE_WIDTH-1:0] Z_QUARTER       = 32'h4000_0000;
  localparam logic [ANGLE_WIDTH-1:0] Z_THREE_QUARTER = 32'hC000_0000;

  localparam logic signed [CURV_WIDTH-1:0] CURV_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [CURV_WIDTH-1:0] CURV_MIN = 32'sh8000_0000;

  typedef enum logic [1:0] {
    STAT_OK,
    STAT_SAT,
    STAT_DEGEN,
    STAT_SHORT
  } status_e;

  typedef enum logic [2:0] {
    MS_DXX,
    MS_DYY,
    MS_P1,
    MS_P2,
    MS_B00,
    MS_B01,
    MS_B10,
    MS_B11
  } mul_sel_e;

  typedef enum logic [2:0] {
    CS_IDLE,
    CS_SETUP,
    CS_MULA,
    CS_SQRT,
    CS_MULB,
    CS_DIV,
    CS_EMIT
  } ctrl_state_e;

  typedef struct packed {
    logic     load;
    logic     setup;
    logic     front;
    logic     mul_en;
    mul_sel_e mul_sel;
    logic     acc_en;
    logic     sqrt_init;
    logic     sqrt_step;
    logic     div_init;
    logic     div_step;
    logic     emit;
    logic     short_res;
    logic     out_last;
  } cmd_t;

  typedef struct packed {
    logic out_free;
    logic cordic_done;
    logic degen;
  } dp_stat_t;

  // atan(2^-i) with 2^31 = pi
  function automatic logic [ANGLE_WIDTH-1:0] cordic_angle(input logic [ANGLE_IDX_W-1:0] idx);
    logic [ANGLE_WIDTH-1:0] a;
    case (idx)
      5'd0:    a = 32'd536870912;
      5'd1:    a = 32'd316933406;
      5'd2:    a = 32'd167458907;
      5'd3:    a = 32'd85004756;
      5'd4:    a = 32'd42667331;
      5'd5:    a = 32'd21354465;
      5'd6:    a = 32'd10679838;
      5'd7:    a = 32'd5340245;
      5'd8:    a = 32'd2670163;
      5'd9:    a = 32'd1335087;
      5'd10:   a = 32'd667544;
      5'd11:   a = 32'd333772;
      5'd12:   a = 32'd166886;
      5'd13:   a = 32'd83443;
      5'd14:   a = 32'd41722;
      5'd15:   a = 32'd20861;
      5'd16:   a = 32'd10430;
      5'd17:   a = 32'd5215;
      5'd18:   a = 32'd2608;
      5'd19:   a = 32'd1304;
      5'd20:   a = 32'd652;
      5'd21:   a = 32'd326;
      5'd22:   a = 32'd163;
      5'd23:   a = 32'd81;
      default: a = '0;
    endcase
    return a;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/phc_cordic.sv -----
// vectoring cordic that turns a step vector into a heading angle
`default_nettype none

module phc_cordic #(
  parameter int COORD_WIDTH   = 24,
  parameter int HEADING_WIDTH = 16,
  parameter int CORDIC_STEPS  = 16
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            start_i,
  input  wire logic signed [COORD_WIDTH:0]     dx_i,
  input  wire logic signed [COORD_WIDTH:0]     dy_i,
  output logic signed [HEADING_WIDTH-1:0]      heading_o,
  output logic                                 done_o
);

  localparam int DW  = COORD_WIDTH + 1;
  localparam int VW  = DW + phc_pkg::CORDIC_PRESHIFT + 3;
  localparam int CIW = $clog2(CORDIC_STEPS + 1);
  localparam int SH  = phc_pkg::ANGLE_WIDTH - HEADING_WIDTH;

  logic signed [VW-1:0] vx0, vy0, vx_init, vy_init;
  logic [phc_pkg::ANGLE_WIDTH-1:0] z_init, ang, z_round;
  logic signed [VW-1:0] vx_q, vy_q, xs, ys;
  logic [phc_pkg::ANGLE_WIDTH-1:0] z_q;
  logic [CIW-1:0] cnt_q;
  logic busy_q;

  assign vx0 = VW'(dx_i) <<< phc_pkg::CORDIC_PRESHIFT;
  assign vy0 = VW'(dy_i) <<< phc_pkg::CORDIC_PRESHIFT;

  // left half plane is folded into the right by a quarter turn
  always_comb begin
    vx_init = vx0;
    vy_init = vy0;
    z_init  = '0;
    if (vx0 < 0) begin
      if (vy0 >= 0) begin
        vx_init = vy0;
        vy_init = -vx0;
        z_init  = phc_pkg::Z_QUARTER;
      end else begin
        vx_init = -vy0;
        vy_init = vx0;
        z_init  = phc_pkg::Z_THREE_QUARTER;
      end
    end
  end

  assign xs  = vx_q >>> cnt_q;
  assign ys  = vy_q >>> cnt_q;
  assign ang = phc_pkg::cordic_angle(phc_pkg::ANGLE_IDX_W'(cnt_q));

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      vx_q <= vx_init;
      vy_q <= vy_init;
      z_q  <= z_init;
    end else if (busy_q) begin
      if (vy_q > 0) begin
        vx_q <= vx_q + ys;
        vy_q <= vy_q - xs;
        z_q  <= z_q + ang;
      end else if (vy_q < 0) begin
        vx_q <= vx_q - ys;
        vy_q <= vy_q + xs;
        z_q  <= z_q - ang;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= '0;
    end else if (busy_q) begin
      if (cnt_q == CIW'(CORDIC_STEPS - 1)) begin
        busy_q <= 1'b0;
      end
      cnt_q <= cnt_q + 1'b1;
    end
  end

  // round half up, +pi wraps to -pi
  assign z_round   = z_q + (phc_pkg::ANGLE_WIDTH'(1) << (SH - 1));
  assign heading_o = $signed(z_round[phc_pkg::ANGLE_WIDTH-1 -: HEADING_WIDTH]);
  assign done_o    = !busy_q;

endmodule

`default_nettype wire

// ----- rtl/phc_datapath.sv -----
// point window, shared multiplier, root and divide units and the result register
`default_nettype none

module phc_datapath #(
  parameter int COORD_WIDTH   = 24,
  parameter int HEADING_WIDTH = 16,
  parameter int CORDIC_STEPS  = 16
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic signed [COORD_WIDTH-1:0]       x_i,
  input  wire logic signed [COORD_WIDTH-1:0]       y_i,
  input  wire phc_pkg::cmd_t                       cmd_i,
  output phc_pkg::dp_stat_t                        stat_o,
  input  wire logic                                out_ready_i,
  output logic                                     out_valid_o,
  output logic signed [HEADING_WIDTH-1:0]          heading_o,
  output logic signed [phc_pkg::CURV_WIDTH-1:0]    curvature_o,
  output logic [1:0]                               status_o,
  output logic                                     last_o
);

  localparam int CW   = COORD_WIDTH;
  localparam int DW   = CW + 1;
  localparam int SDW  = CW + 2;
  localparam int MW   = CW + 3;
  localparam int PW   = 2 * MW;
  localparam int SQW  = 2 * CW + 2;
  localparam int HS   = CW + 1;
  localparam int RW   = CW + 1 + phc_pkg::SQRT_SHIFT / 2;
  localparam int HR   = (RW + 1) / 2;
  localparam int RPW  = 2 * HR;
  localparam int BW   = SQW + RPW;
  localparam int NW   = 2 * CW + 4;
  localparam int RADW = 2 * RW;
  localparam int REMW = RW + 2;
  localparam int PRE  = phc_pkg::CURV_SHIFT - phc_pkg::QUOT_BITS;
  localparam int AW   = NW + PRE;
  localparam int DVW  = ((AW > BW) ? AW : BW) + 1;
  localparam int QB   = phc_pkg::QUOT_BITS;

  // window of the three newest points, oldest at index 0
  logic signed [CW-1:0] xw_q [3];
  logic signed [CW-1:0] yw_q [3];

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      xw_q[0] <= xw_q[1];
      xw_q[1] <= xw_q[2];
      xw_q[2] <= x_i;
      yw_q[0] <= yw_q[1];
      yw_q[1] <= yw_q[2];
      yw_q[2] <= y_i;
    end
  end

  logic signed [DW-1:0]  dx_d, dy_d, dx_q, dy_q;
  logic signed [SDW-1:0] ddx_d, ddy_d, ddx_q, ddy_q;

  always_comb begin
    if (cmd_i.front) begin
      dx_d = DW'(xw_q[2]) - DW'(xw_q[1]);
      dy_d = DW'(yw_q[2]) - DW'(yw_q[1]);
    end else begin
      dx_d = DW'(xw_q[1]) - DW'(xw_q[0]);
      dy_d = DW'(yw_q[1]) - DW'(yw_q[0]);
    end
    ddx_d = SDW'(xw_q[2]) + SDW'(xw_q[0]) - (SDW'(xw_q[1]) <<< 1);
    ddy_d = SDW'(yw_q[2]) + SDW'(yw_q[0]) - (SDW'(yw_q[1]) <<< 1);
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.setup) begin
      dx_q  <= dx_d;
      dy_q  <= dy_d;
      ddx_q <= ddx_d;
      ddy_q <= ddy_d;
    end
  end

  logic signed [HEADING_WIDTH-1:0] cordic_heading;
  logic cordic_done;

  phc_cordic #(
    .COORD_WIDTH  (COORD_WIDTH),
    .HEADING_WIDTH(HEADING_WIDTH),
    .CORDIC_STEPS (CORDIC_STEPS)
  ) u_cordic (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (cmd_i.setup),
    .dx_i     (dx_d),
    .dy_i     (dy_d),
    .heading_o(cordic_heading),
    .done_o   (cordic_done)
  );

  // shared multiplier, product registered and folded in the next cycle
  logic [SQW-1:0]          s_q;
  logic signed [NW-1:0]    n_q;
  logic [BW-1:0]           b_q;
  logic [RW-1:0]           root_q;
  logic [RPW-1:0]          root_pad;
  logic signed [MW-1:0]    ma, mb;
  logic signed [PW-1:0]    prod_q;
  phc_pkg::mul_sel_e       tag_q;

  assign root_pad = RPW'(root_q);

  always_comb begin
    case (cmd_i.mul_sel)
      phc_pkg::MS_DXX: begin
        ma = MW'(dx_q);
        mb = MW'(dx_q);
      end
      phc_pkg::MS_DYY: begin
        ma = MW'(dy_q);
        mb = MW'(dy_q);
      end
      phc_pkg::MS_P1: begin
        ma = MW'(ddy_q);
        mb = MW'(dx_q);
      end
      phc_pkg::MS_P2: begin
        ma = MW'(ddx_q);
        mb = MW'(dy_q);
      end
      phc_pkg::MS_B00: begin
        ma = MW'($signed({1'b0, s_q[HS-1:0]}));
        mb = MW'($signed({1'b0, root_pad[HR-1:0]}));
      end
      phc_pkg::MS_B01: begin
        ma = MW'($signed({1'b0, s_q[HS-1:0]}));
        mb = MW'($signed({1'b0, root_pad[RPW-1:HR]}));
      end
      phc_pkg::MS_B10: begin
        ma = MW'($signed({1'b0, s_q[SQW-1:HS]}));
        mb = MW'($signed({1'b0, root_pad[HR-1:0]}));
      end
      phc_pkg::MS_B11: begin
        ma = MW'($signed({1'b0, s_q[SQW-1:HS]}));
        mb = MW'($signed({1'b0, root_pad[RPW-1:HR]}));
      end
      default: begin
        ma = '0;
        mb = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_en) begin
      prod_q <= ma * mb;
      tag_q  <= cmd_i.mul_sel;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.acc_en) begin
      case (tag_q)
        phc_pkg::MS_DXX: s_q <= SQW'(prod_q);
        phc_pkg::MS_DYY: s_q <= s_q + SQW'(prod_q);
        phc_pkg::MS_P1:  n_q <= NW'(prod_q);
        phc_pkg::MS_P2:  n_q <= n_q - NW'(prod_q);
        phc_pkg::MS_B00: b_q <= BW'(prod_q);
        phc_pkg::MS_B01: b_q <= b_q + (BW'(prod_q) << HR);
        phc_pkg::MS_B10: b_q <= b_q + (BW'(prod_q) << HS);
        phc_pkg::MS_B11: b_q <= b_q + (BW'(prod_q) << (HS + HR));
        default: ;
      endcase
    end
  end

  // integer square root of s * 2^32, two radicand bits a cycle
  logic [RADW-1:0]   rad_q;
  logic [REMW-1:0]   rem_q;
  logic [REMW+1:0]   rem2, trial;
  logic              sge;
  logic              nsign_q;
  logic [NW-1:0]     nmag_q;

  assign rem2  = {rem_q, rad_q[RADW-1 -: 2]};
  assign trial = (REMW + 2)'({root_q, 2'b01});
  assign sge   = (rem2 >= trial);

  always_ff @(posedge clk_i) begin
    if (cmd_i.sqrt_init) begin
      rad_q   <= {s_q, {phc_pkg::SQRT_SHIFT{1'b0}}};
      rem_q   <= '0;
      root_q  <= '0;
      nsign_q <= n_q[NW-1];
      nmag_q  <= n_q[NW-1] ? $unsigned(-n_q) : $unsigned(n_q);
    end else if (cmd_i.sqrt_step) begin
      rad_q  <= rad_q << 2;
      rem_q  <= sge ? REMW'(rem2 - trial) : REMW'(rem2);
      root_q <= {root_q[RW-2:0], sge};
    end
  end

  // restoring divide for the low quotient bits, high bits only flag overflow
  logic [DVW-1:0] a0, bx, r_q, r2;
  logic [QB-1:0]  q_q;
  logic           dge, ovf_q;

  assign a0  = DVW'(nmag_q) << PRE;
  assign bx  = DVW'(b_q);
  assign r2  = r_q << 1;
  assign dge = (r2 >= bx);

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_init) begin
      r_q   <= a0;
      ovf_q <= (a0 >= bx);
      q_q   <= '0;
    end else if (cmd_i.div_step) begin
      r_q <= dge ? (r2 - bx) : r2;
      q_q <= {q_q[QB-2:0], dge};
    end
  end

  // result assembly and output register
  logic signed [phc_pkg::CURV_WIDTH-1:0] qx, curv_d, curv_q;
  logic signed [HEADING_WIDTH-1:0]       head_d, head_q;
  phc_pkg::status_e                      stat_d, stat_q;
  logic                                  degen, vld_q, last_q;

  assign degen = (dx_q == '0) && (dy_q == '0);
  assign qx    = $signed({1'b0, q_q});

  always_comb begin
    head_d = cordic_heading;
    if (cmd_i.short_res) begin
      head_d = '0;
      curv_d = '0;
      stat_d = phc_pkg::STAT_SHORT;
    end else if (degen) begin
      head_d = '0;
      curv_d = '0;
      stat_d = phc_pkg::STAT_DEGEN;
    end else if (ovf_q) begin
      curv_d = nsign_q ? phc_pkg::CURV_MIN : phc_pkg::CURV_MAX;
      stat_d = phc_pkg::STAT_SAT;
    end else begin
      curv_d = nsign_q ? -qx : qx;
      stat_d = phc_pkg::STAT_OK;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      head_q <= head_d;
      curv_q <= curv_d;
      stat_q <= stat_d;
      last_q <= cmd_i.out_last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (cmd_i.emit) begin
      vld_q <= 1'b1;
    end else if (out_ready_i) begin
      vld_q <= 1'b0;
    end
  end

  assign out_valid_o        = vld_q;
  assign heading_o          = head_q;
  assign curvature_o        = curv_q;
  assign status_o           = stat_q;
  assign last_o             = last_q;
  assign stat_o.out_free    = !vld_q || out_ready_i;
  assign stat_o.cordic_done = cordic_done;
  assign stat_o.degen       = degen;

endmodule

`default_nettype wire

// ----- rtl/phc_ctrl.sv -----
// controller that tracks the path position and sequences the datapath per result
`default_nettype none
`include "assert_macros.svh"

module phc_ctrl #(
  parameter int COORD_WIDTH = 24
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  input  wire logic              in_last_i,
  output logic                   in_ready_o,
  output phc_pkg::cmd_t          cmd_o,
  input  wire phc_pkg::dp_stat_t stat_i
);

  localparam int RW   = COORD_WIDTH + 1 + phc_pkg::SQRT_SHIFT / 2;
  localparam int CNTW = $clog2(RW + 1);

  phc_pkg::ctrl_state_e state_q, state_d;
  logic [CNTW-1:0] cnt_q, cnt_d;
  logic [1:0] seen_q, seen_d;
  logic last_q, last_d, short_q, short_d, rep_q, rep_d;
  logic recalc_q, recalc_d, front_q, front_d, olast_q, olast_d;
  logic emit_ok;

  assign emit_ok = stat_i.out_free && stat_i.cordic_done;

  always_comb begin
    state_d  = state_q;
    cnt_d    = cnt_q;
    seen_d   = seen_q;
    last_d   = last_q;
    short_d  = short_q;
    rep_d    = rep_q;
    recalc_d = recalc_q;
    front_d  = front_q;
    olast_d  = olast_q;
    case (state_q)
      phc_pkg::CS_IDLE: begin
        if (in_valid_i) begin
          last_d = in_last_i;
          case (seen_q)
            2'd0: begin
              if (in_last_i) begin
                state_d  = phc_pkg::CS_EMIT;
                short_d  = 1'b1;
                olast_d  = 1'b1;
                rep_d    = 1'b0;
                recalc_d = 1'b0;
              end else begin
                seen_d = 2'd1;
              end
            end
            2'd1: begin
              if (in_last_i) begin
                state_d  = phc_pkg::CS_EMIT;
                short_d  = 1'b1;
                olast_d  = 1'b0;
                rep_d    = 1'b1;
                recalc_d = 1'b0;
                seen_d   = 2'd0;
              end else begin
                seen_d = 2'd2;
              end
            end
            default: begin
              // third point gives the first two results, later points one each, a final one two
              state_d  = phc_pkg::CS_SETUP;
              seen_d   = in_last_i ? 2'd0 : 2'd3;
              short_d  = 1'b0;
              olast_d  = 1'b0;
              front_d  = (seen_q == 2'd3);
              rep_d    = (seen_q == 2'd3) && in_last_i;
              recalc_d = (seen_q == 2'd2);
            end
          endcase
        end
      end
      phc_pkg::CS_SETUP: begin
        state_d = phc_pkg::CS_MULA;
        cnt_d   = '0;
      end
      phc_pkg::CS_MULA: begin
        if (cnt_q == '0 && stat_i.degen) begin
          state_d = phc_pkg::CS_EMIT;
        end else if (cnt_q == CNTW'(phc_pkg::MUL_STEPS)) begin
          state_d = phc_pkg::CS_SQRT;
          cnt_d   = '0;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      phc_pkg::CS_SQRT: begin
        if (cnt_q == CNTW'(RW)) begin
          state_d = phc_pkg::CS_MULB;
          cnt_d   = '0;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      phc_pkg::CS_MULB: begin
        if (cnt_q == CNTW'(phc_pkg::MUL_STEPS)) begin
          state_d = phc_pkg::CS_DIV;
          cnt_d   = '0;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      phc_pkg::CS_DIV: begin
        if (cnt_q == CNTW'(phc_pkg::QUOT_BITS)) begin
          state_d = phc_pkg::CS_EMIT;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      phc_pkg::CS_EMIT: begin
        if (emit_ok) begin
          if (rep_q) begin
            // final point repeats the values of the one before it
            rep_d   = 1'b0;
            olast_d = 1'b1;
          end else if (recalc_q) begin
            recalc_d = 1'b0;
            front_d  = 1'b1;
            olast_d  = last_q;
            state_d  = phc_pkg::CS_SETUP;
          end else begin
            state_d = phc_pkg::CS_IDLE;
          end
        end
      end
      default: state_d = phc_pkg::CS_IDLE;
    endcase
  end

  always_comb begin
    cmd_o           = '0;
    cmd_o.front     = front_q;
    cmd_o.short_res = short_q;
    cmd_o.out_last  = olast_q;
    cmd_o.mul_sel   = phc_pkg::MS_DXX;
    in_ready_o      = 1'b0;
    case (state_q)
      phc_pkg::CS_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      phc_pkg::CS_SETUP: cmd_o.setup = 1'b1;
      phc_pkg::CS_MULA: begin
        cmd_o.mul_en = (cnt_q < CNTW'(phc_pkg::MUL_STEPS));
        cmd_o.acc_en = (cnt_q != '0);
        case (cnt_q[1:0])
          2'd0:    cmd_o.mul_sel = phc_pkg::MS_DXX;
          2'd1:    cmd_o.mul_sel = phc_pkg::MS_DYY;
          2'd2:    cmd_o.mul_sel = phc_pkg::MS_P1;
          default: cmd_o.mul_sel = phc_pkg::MS_P2;
        endcase
      end
      phc_pkg::CS_SQRT: begin
        cmd_o.sqrt_init = (cnt_q == '0);
        cmd_o.sqrt_step = (cnt_q != '0);
      end
      phc_pkg::CS_MULB: begin
        cmd_o.mul_en = (cnt_q < CNTW'(phc_pkg::MUL_STEPS));
        cmd_o.acc_en = (cnt_q != '0);
        case (cnt_q[1:0])
          2'd0:    cmd_o.mul_sel = phc_pkg::MS_B00;
          2'd1:    cmd_o.mul_sel = phc_pkg::MS_B01;
          2'd2:    cmd_o.mul_sel = phc_pkg::MS_B10;
          default: cmd_o.mul_sel = phc_pkg::MS_B11;
        endcase
      end
      phc_pkg::CS_DIV: begin
        cmd_o.div_init = (cnt_q == '0);
        cmd_o.div_step = (cnt_q != '0);
      end
      phc_pkg::CS_EMIT: cmd_o.emit = emit_ok;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= phc_pkg::CS_IDLE;
      cnt_q    <= '0;
      seen_q   <= '0;
      last_q   <= 1'b0;
      short_q  <= 1'b0;
      rep_q    <= 1'b0;
      recalc_q <= 1'b0;
      front_q  <= 1'b0;
      olast_q  <= 1'b0;
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      seen_q   <= seen_d;
      last_q   <= last_d;
      short_q  <= short_d;
      rep_q    <= rep_d;
      recalc_q <= recalc_d;
      front_q  <= front_d;
      olast_q  <= olast_d;
    end
  end

  `ASSERT_AT(a_emit_into_free, clk_i, rst_ni, cmd_o.emit |-> stat_i.out_free, "emit while output full")
  `ASSERT_AT(a_seen_only_on_beat, clk_i, rst_ni, !(in_valid_i && in_ready_o) |=> $stable(seen_q), "point count moved without a beat")
  `ASSERT_AT(a_repeat_stays, clk_i, rst_ni, (cmd_o.emit && rep_q) |=> (state_q == phc_pkg::CS_EMIT) && olast_q, "repeat result not marked last")
  `ASSERT_NEVER(a_rep_and_recalc, clk_i, rst_ni, rep_q && recalc_q, "repeat and recompute both pending")

endmodule

`default_nettype wire

// ----- rtl/path_heading_curvature.sv -----
// top level: heading and curvature of a streamed planar path
//
//  channel   dir  tdata (low bit up)               tuser    tlast
//  s_axis    in   point_x, point_y                 -        last_point
//  m_axis    out  heading, curvature               status   last_result
//
// each result is worked out in steps: setup, multiply, the bit-pair square root,
// multiply again and the divide
// the root and divide units share one datapath, so one result is in work at a time
// the third point of a path leads to two computed results, back to back
// a new point is taken whenever the controller is idle, even with a result held
// reset is asynchronous, active low, and needs no clearing pass
`default_nettype none

module path_heading_curvature #(
  parameter int COORD_WIDTH   = 24,
  parameter int HEADING_WIDTH = 16,
  parameter int CORDIC_STEPS  = 16
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          s_axis_tvalid,
  output logic                               s_axis_tready,
  input  wire logic [((2*COORD_WIDTH+7)/8)*8-1:0] s_axis_tdata,  // point_x, point_y
  input  wire logic                          s_axis_tlast,
  output logic                               m_axis_tvalid,
  input  wire logic                          m_axis_tready,
  output logic [((HEADING_WIDTH+32+7)/8)*8-1:0] m_axis_tdata,    // heading, curvature
  output logic [1:0]                         m_axis_tuser,       // status
  output logic                               m_axis_tlast
);

  localparam int OUT_TDW = ((HEADING_WIDTH + phc_pkg::CURV_WIDTH + 7) / 8) * 8;

  logic signed [COORD_WIDTH-1:0] point_x, point_y;
  logic signed [HEADING_WIDTH-1:0] heading;
  logic signed [phc_pkg::CURV_WIDTH-1:0] curvature;
  phc_pkg::cmd_t cmd;
  phc_pkg::dp_stat_t dp_stat;

  assign point_x = $signed(s_axis_tdata[COORD_WIDTH-1:0]);
  assign point_y = $signed(s_axis_tdata[2*COORD_WIDTH-1:COORD_WIDTH]);

  phc_ctrl #(
    .COORD_WIDTH(COORD_WIDTH)
  ) u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(s_axis_tvalid),
    .in_last_i (s_axis_tlast),
    .in_ready_o(s_axis_tready),
    .cmd_o     (cmd),
    .stat_i    (dp_stat)
  );

  phc_datapath #(
    .COORD_WIDTH  (COORD_WIDTH),
    .HEADING_WIDTH(HEADING_WIDTH),
    .CORDIC_STEPS (CORDIC_STEPS)
  ) u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .x_i        (point_x),
    .y_i        (point_y),
    .cmd_i      (cmd),
    .stat_o     (dp_stat),
    .out_ready_i(m_axis_tready),
    .out_valid_o(m_axis_tvalid),
    .heading_o  (heading),
    .curvature_o(curvature),
    .status_o   (m_axis_tuser),
    .last_o     (m_axis_tlast)
  );

  assign m_axis_tdata = OUT_TDW'({curvature, heading});

endmodule

`default_nettype wire

// ----- sim/path_heading_curvature_tb.sv -----
// self-checking testbench of the path heading and curvature block
`default_nettype none

module path_heading_curvature_tb;

  localparam int CW = 24;
  localparam int HW = 16;
  localparam int CSTEPS = 16;
  localparam int MAX_C = (1 << (CW - 1)) - 1;
  localparam int MIN_C = -(1 << (CW - 1));
  localparam int RANDOM_POINTS = 1850;

  // atan(2^-i), 2^31 = pi
  localparam int unsigned ATAN_STEP[CSTEPS] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10679838, 5340245, 2670163, 1335087, 667544, 333772,
    166886, 83443, 41722, 20861};

  typedef struct packed {
    logic [HW-1:0]    heading;
    logic [31:0]      curv;
    phc_pkg::status_e status;
    logic             last;
  } geo_res_t;

  typedef struct {
    int       x;
    int       y;
    bit       last;
    bit       typed;
    int       cnt;
    geo_res_t val;
  } point_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [47:0] s_axis_tdata = '0;  // point_x, point_y
  logic s_axis_tlast = 1'b0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [47:0] m_axis_tdata;       // heading, curvature
  logic [1:0] m_axis_tuser;        // status
  logic m_axis_tlast;

  path_heading_curvature uut (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tlast,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser, .m_axis_tlast
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  geo_res_t   pending_geo[$];
  point_row_t directed_rows[$];
  int         mismatches = 0;
  int         sender_idle_pct = 0;
  int         recv_stall_pct = 0;

  // path window, newest last
  longint win_x[3];
  longint win_y[3];
  int     pts_in_path = 0;
  geo_res_t step_res[2];
  int     step_cnt;

  function automatic logic [HW-1:0] cordic_heading(longint dx, longint dy);
    longint vx, vy, t, xs, ys;
    logic [31:0] z;
    vx = dx * 64'sd16777216;
    vy = dy * 64'sd16777216;
    z = '0;
    if (vx < 0) begin
      if (vy >= 0) begin
        t = vx; vx = vy; vy = -t; z = phc_pkg::Z_QUARTER;
      end else begin
        t = vx; vx = -vy; vy = t; z = phc_pkg::Z_THREE_QUARTER;
      end
    end
    for (int i = 0; i < CSTEPS; i++) begin
      xs = vx >>> i;
      ys = vy >>> i;
      if (vy > 0) begin
        vx += ys; vy -= xs; z += ATAN_STEP[i];
      end else if (vy < 0) begin
        vx -= ys; vy += xs; z -= ATAN_STEP[i];
      end
    end
    z = z + (32'd1 << (32 - HW - 1));
    return z[31 -: HW];
  endfunction

  function automatic logic [127:0] root_floor(logic [127:0] n);
    logic [127:0] r, t;
    r = '0;
    for (int k = 63; k >= 0; k--) begin
      t = r | (128'd1 << k);
      if (t * t <= n) r = t;
    end
    return r;
  endfunction

  function automatic geo_res_t curve_at(longint dx, longint dy, longint ddx, longint ddy,
                                        logic last);
    geo_res_t r;
    longint sq, num;
    logic [127:0] s128, b, a, q;
    r.last = last;
    if (dx == 0 && dy == 0) begin
      r.heading = '0; r.curv = '0; r.status = phc_pkg::STAT_DEGEN;
      return r;
    end
    r.heading = cordic_heading(dx, dy);
    sq = dx * dx + dy * dy;
    num = ddy * dx - ddx * dy;
    s128 = 128'(sq);
    b = s128 * root_floor(s128 << 32);
    a = 128'(num < 0 ? -num : num) << 40;
    q = a / b;
    if (q >= 128'h8000_0000) begin
      r.curv = (num < 0) ? phc_pkg::CURV_MIN : phc_pkg::CURV_MAX;
      r.status = phc_pkg::STAT_SAT;
    end else begin
      r.curv = (num < 0) ? -q[31:0] : q[31:0];
      r.status = phc_pkg::STAT_OK;
    end
    return r;
  endfunction

  // advance the path window by one point and work out its results
  task automatic take_point(logic [CW-1:0] px, logic [CW-1:0] py, logic last);
    longint ddx, ddy;
    int n;
    geo_res_t short_res;
    n = pts_in_path;
    win_x[0] = win_x[1]; win_x[1] = win_x[2]; win_x[2] = longint'(signed'(px));
    win_y[0] = win_y[1]; win_y[1] = win_y[2]; win_y[2] = longint'(signed'(py));
    short_res = '{heading: '0, curv: '0, status: phc_pkg::STAT_SHORT, last: 1'b0};
    step_cnt = 0;
    if (n == 0) begin
      if (last) begin
        step_res[0] = short_res; step_res[0].last = 1'b1; step_cnt = 1;
      end
      pts_in_path = last ? 0 : 1;
      return;
    end
    if (n == 1) begin
      if (last) begin
        step_res[0] = short_res;
        step_res[1] = short_res; step_res[1].last = 1'b1;
        step_cnt = 2;
      end
      pts_in_path = last ? 0 : 2;
      return;
    end
    ddx = win_x[2] + win_x[0] - 2 * win_x[1];
    ddy = win_y[2] + win_y[0] - 2 * win_y[1];
    pts_in_path = last ? 0 : 3;
    if (n == 2) begin
      step_res[0] = curve_at(win_x[1] - win_x[0], win_y[1] - win_y[0], ddx, ddy, 1'b0);
      step_res[1] = curve_at(win_x[2] - win_x[1], win_y[2] - win_y[1], ddx, ddy, last);
      step_cnt = 2;
    end else begin
      step_res[0] = curve_at(win_x[2] - win_x[1], win_y[2] - win_y[1], ddx, ddy, 1'b0);
      step_cnt = 1;
      if (last) begin
        step_res[1] = step_res[0]; step_res[1].last = 1'b1; step_cnt = 2;
      end
    end
  endtask

  // one point over the slave side; typed rows replace the predicted results
  task automatic send_point(point_row_t row);
    if ($urandom_range(99) < sender_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {row.y[CW-1:0], row.x[CW-1:0]};
    s_axis_tlast <= row.last;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    take_point(row.x[CW-1:0], row.y[CW-1:0], row.last);
    if (row.typed) begin
      for (int j = 0; j < row.cnt; j++) begin
        step_res[j] = row.val;
        step_res[j].last = row.last && (j == row.cnt - 1);
      end
      step_cnt = row.cnt;
    end
    for (int j = 0; j < step_cnt; j++) pending_geo = {pending_geo, step_res[j]};
  endtask

  task automatic add_row(int x, int y, bit last, bit typed = 0, int cnt = 0,
                         phc_pkg::status_e st = phc_pkg::STAT_OK);
    point_row_t r;
    r.x = x; r.y = y; r.last = last; r.typed = typed; r.cnt = cnt;
    r.val = '{heading: '0, curv: '0, status: st, last: 1'b0};
    directed_rows = {directed_rows, r};
  endtask

  // result side: stall at random and compare each beat with the oldest expectation
  always @(posedge clk_i) begin
    geo_res_t got, want;
    m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.heading = m_axis_tdata[HW-1:0];
      got.curv = m_axis_tdata[HW +: 32];
      got.status = phc_pkg::status_e'(m_axis_tuser);
      got.last = m_axis_tlast;
      if (pending_geo.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result beat %p", got);
      end else begin
        want = pending_geo.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10) $display("mismatch: expected %p got %p", want, got);
        end
      end
    end
  end

  initial begin
    point_row_t row;
    int sent, len, mode, step_x, step_y, bend, cx, cy;
    win_x = '{0, 0, 0};
    win_y = '{0, 0, 0};

    // single point, two points, all in one place, straight line
    add_row(0, 0, 1, 1, 1, phc_pkg::STAT_SHORT);
    add_row(5, 5, 0, 1, 0);
    add_row(MAX_C, MIN_C, 1, 1, 2, phc_pkg::STAT_SHORT);
    add_row(7, 7, 0, 1, 0);
    add_row(7, 7, 0, 1, 0);
    add_row(7, 7, 1, 1, 2, phc_pkg::STAT_DEGEN);
    add_row(0, 0, 0, 1, 0);
    add_row(256, 0, 0, 1, 0);
    add_row(512, 0, 1, 1, 2, phc_pkg::STAT_OK);
    // coordinate extremes
    add_row(MIN_C, MIN_C, 0);
    add_row(MAX_C, MAX_C, 0);
    add_row(MIN_C, MAX_C, 0);
    add_row(MAX_C, MIN_C, 1);
    // tight bend, leftward heading, vertical line
    add_row(0, 0, 0);
    add_row(1, 0, 0);
    add_row(1, 1, 1);
    add_row(0, 0, 0);
    add_row(-256, 0, 0);
    add_row(-256, -256, 0);
    add_row(0, -512, 1);
    add_row(0, 0, 0);
    add_row(0, 1, 0);
    add_row(0, 2, 1);

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (directed_rows[i]) send_point(directed_rows[i]);

    sent = 0;
    while (sent < RANDOM_POINTS) begin
      case (sent * 4 / RANDOM_POINTS)
        0: begin sender_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin sender_idle_pct = 50; recv_stall_pct = 0;  end
        2: begin sender_idle_pct = 0;  recv_stall_pct = 50; end
        default: begin sender_idle_pct = 24; recv_stall_pct = 24; end
      endcase
      mode = $urandom_range(99);
      len = (mode < 10) ? $urandom_range(1, 2) : $urandom_range(3, 12);
      cx = $urandom_range(0, 2 ** 21) - 2 ** 20;
      cy = $urandom_range(0, 2 ** 21) - 2 ** 20;
      step_x = $urandom_range(0, 8192) - 4096;
      step_y = $urandom_range(0, 8192) - 4096;
      bend = $urandom_range(0, 64) - 32;
      for (int k = 0; k < len; k++) begin
        row.last = (k == len - 1);
        row.typed = 0;
        if (mode >= 85) begin
          // noise over the whole coordinate range
          row.x = int'(signed'(24'($urandom())));
          row.y = int'(signed'(24'($urandom())));
        end else begin
          if ($urandom_range(19) != 0) begin
            cx += step_x;
            cy += step_y;
          end
          step_x += bend;
          step_y -= bend / 2;
          row.x = cx;
          row.y = cy;
        end
        send_point(row);
        sent++;
      end
    end
    s_axis_tvalid <= 1'b0;
    while (pending_geo.size() != 0) @(posedge clk_i);
    repeat (300) @(posedge clk_i);
    if (mismatches == 0 && pending_geo.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #40000000;
    $display("TB_ERROR");
    $finish;
  end

endmodule

`default_nettype wire
